@@ rtl/fda_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point to decimal ASCII unit.
// Used by fda_ctrl, fda_datapath and the top level; depends on nothing.
package fda_pkg;

  // Longest text burst, and the width of the per-burst character counter.
  localparam int MAX_RESULTS = 18;
  localparam int CHAR_CNT_W  = 5;

  // ASCII codes of the emitted characters.
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // Source of the character loaded into the output register.
  typedef enum logic [1:0] {
    SEL_MINUS,
    SEL_INT,
    SEL_DOT,
    SEL_FRAC
  } char_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;
    logic      conv;
    logic      int_shift;
    logic      frac_shift;
    logic      emit;
    char_sel_t sel;
    logic      last;
  } fda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic conv_done;
    logic negative;
    logic int_top_zero;
    logic int_left_zero;
    logic int_left_one;
    logic frac_none;
    logic frac_one;
    logic slot_free;
  } fda_status_t;

endpackage

@@ rtl/fda_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the fixed-point to decimal ASCII unit: bit-serial binary to BCD,
// fraction digit generation by times-ten steps, and the output beat register.
// Depends on fda_pkg; driven by commands from fda_ctrl.
module fda_datapath #(
  parameter int INT_BITS        = 31,
  parameter int FRAC_BITS       = 20,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   negative,
  input  logic [INT_BITS-1:0]    int_part,
  input  logic [FRAC_BITS-1:0]   frac_part,
  input  fda_pkg::fda_cmd_t      cmd,
  output fda_pkg::fda_status_t   status,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [7:0]             char_code,
  output logic                   last
);
  import fda_pkg::*;

  // Decimal digits needed for the largest integer part (floor(n*log10(2)) + 1).
  localparam int NDIG        = ((INT_BITS * 1233) >> 12) + 1;
  localparam int BCD_W       = 4 * NDIG;
  localparam int FBCD_W      = 4 * MAX_FRAC_DIGITS;
  localparam int CONV_CYCLES = (INT_BITS > MAX_FRAC_DIGITS) ? INT_BITS : MAX_FRAC_DIGITS;
  localparam int CNT_W       = $clog2(CONV_CYCLES + 1);
  localparam int IDX_W       = $clog2(NDIG + 1);
  localparam int FC_W        = $clog2(MAX_FRAC_DIGITS + 1);

  logic [INT_BITS-1:0]  bin;
  logic [BCD_W-1:0]     bcd;
  logic [FRAC_BITS-1:0] frac_rem;
  logic [FBCD_W-1:0]    fbcd;
  logic [FC_W-1:0]      fcount;
  logic [IDX_W-1:0]     int_left;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;

  logic [BCD_W-1:0]     bcd_adj;
  logic [FRAC_BITS+3:0] frac_x10;
  logic [3:0]           frac_digit;
  logic                 int_active;
  logic                 frac_active;
  logic [7:0]           char_mux;

  // Double-dabble correction: add three to every BCD digit of five or more.
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  // Remainder times ten; the top nibble is the next fraction digit.
  assign frac_x10   = {1'b0, frac_rem, 3'b000} + {3'b000, frac_rem, 1'b0};
  assign frac_digit = frac_x10[FRAC_BITS+3 -: 4];

  // The integer and fraction conversions share one step counter.
  assign int_active  = (cnt < CNT_W'(INT_BITS));
  assign frac_active = (cnt < CNT_W'(MAX_FRAC_DIGITS));

  // Conversion and digit shift registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= int_part;
      bcd      <= '0;
      frac_rem <= frac_part;
      fbcd     <= '0;
      fcount   <= '0;
      int_left <= IDX_W'(NDIG);
      cnt      <= '0;
      neg      <= negative;
    end else begin
      if (cmd.conv) begin
        cnt <= cnt + 1'b1;
        if (int_active) begin
          bcd <= BCD_W'({bcd_adj, bin[INT_BITS-1]});
          bin <= INT_BITS'({bin, 1'b0});
        end
        // A fraction digit counts only up to the last nonzero one, so
        // trailing zeros are never emitted.
        if (frac_active) begin
          frac_rem <= frac_x10[FRAC_BITS-1:0];
          fbcd     <= FBCD_W'({fbcd, frac_digit});
          if (frac_digit != 4'd0) begin
            fcount <= FC_W'(cnt) + 1'b1;
          end
        end
      end
      if (cmd.int_shift) begin
        bcd      <= BCD_W'({bcd, 4'h0});
        int_left <= int_left - 1'b1;
      end
      if (cmd.frac_shift) begin
        fbcd   <= FBCD_W'({fbcd, 4'h0});
        fcount <= fcount - 1'b1;
      end
    end
  end

  // Character selection for the next output beat.
  always_comb begin
    unique case (cmd.sel)
      SEL_MINUS: char_mux = CHAR_MINUS;
      SEL_INT:   char_mux = CHAR_ZERO + {4'h0, bcd[BCD_W-1 -: 4]};
      SEL_DOT:   char_mux = CHAR_DOT;
      SEL_FRAC:  char_mux = CHAR_ZERO + {4'h0, fbcd[FBCD_W-1 -: 4]};
    endcase
  end

  // Output beat register; it frees up in the cycle the beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      char_code <= char_mux;
      last      <= cmd.last;
    end
  end

  // Status back to the controller.
  assign status.conv_done     = (cnt == CNT_W'(CONV_CYCLES - 1));
  assign status.negative      = neg;
  assign status.int_top_zero  = (bcd[BCD_W-1 -: 4] == 4'h0);
  assign status.int_left_zero = (int_left == '0);
  assign status.int_left_one  = (int_left == IDX_W'(1));
  assign status.frac_none     = (fcount == '0);
  assign status.frac_one      = (fcount == FC_W'(1));
  assign status.slot_free     = !out_valid || !out_stall;

endmodule

@@ rtl/fda_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the fixed-point to decimal ASCII unit: sequences conversion,
// leading-zero skip and character emission. Depends on fda_pkg.
module fda_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fda_pkg::fda_status_t status,
  output fda_pkg::fda_cmd_t    cmd
);
  import fda_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_INT,
    ST_DOT,
    ST_FRAC
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [CHAR_CNT_W-1:0] nchar;
  logic [CHAR_CNT_W-1:0] nchar_next;
  logic                  last_cap;

  // The burst is cut at its longest allowed length.
  assign last_cap = (nchar == CHAR_CNT_W'(MAX_RESULTS - 1));

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    nchar_next = nchar;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_done) begin
          state_next = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!status.negative) begin
          state_next = ST_SKIP;
        end else if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_MINUS;
          cmd.last   = last_cap;
          state_next = last_cap ? ST_IDLE : ST_SKIP;
        end
      end
      // Drop leading zero digits, one per cycle.
      ST_SKIP: begin
        if (status.int_left_zero) begin
          state_next = ST_DOT;
        end else if (!status.int_top_zero) begin
          state_next = ST_INT;
        end else begin
          cmd.int_shift = 1'b1;
        end
      end
      ST_INT: begin
        if (status.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.int_shift = 1'b1;
          cmd.sel       = SEL_INT;
          cmd.last      = last_cap;
          if (last_cap) begin
            state_next = ST_IDLE;
          end else if (status.int_left_one) begin
            state_next = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        if (status.slot_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_DOT;
          cmd.last   = last_cap || status.frac_none;
          state_next = (last_cap || status.frac_none) ? ST_IDLE : ST_FRAC;
        end
      end
      ST_FRAC: begin
        if (status.slot_free) begin
          cmd.emit       = 1'b1;
          cmd.frac_shift = 1'b1;
          cmd.sel        = SEL_FRAC;
          cmd.last       = last_cap || status.frac_one;
          if (last_cap || status.frac_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // Count characters of the current burst.
    if (cmd.load) begin
      nchar_next = '0;
    end else if (cmd.emit) begin
      nchar_next = nchar + 1'b1;
    end
  end

  // State and burst counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nchar <= '0;
    end else begin
      state <= state_next;
      nchar <= nchar_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  // A character is only loaded when the output register can take it.
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.slot_free)
    else $error("character emitted while output register is occupied");

  // The flagged final character ends the burst.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the last character");

  // A burst never grows past its maximum length.
  a_burst_len: assert property (@(posedge clk) disable iff (rst)
    nchar <= CHAR_CNT_W'(MAX_RESULTS))
    else $error("burst longer than the maximum character count");

endmodule

@@ rtl/fixed_to_decimal_ascii_unit.sv @@
`timescale 1ns / 1ps
// Fixed-point to decimal ASCII unit: turns one sign-magnitude fixed-point
// number into its decimal text, one ASCII character per output beat.
// Depends on fda_pkg, fda_ctrl and fda_datapath.
//
// Input channel: in_valid / in_stall carry negative, int_part and frac_part.
// Output channel: out_valid / out_stall carry char_code and last; last marks
// the final character of each number's text ("-", integer digits without
// leading zeros, ".", then up to MAX_FRAC_DIGITS truncated fraction digits
// with trailing zeros dropped).
// A number is taken only while the unit is idle. The integer part goes through
// a bit-serial binary to BCD converter, with the fraction digits produced
// alongside. For a negative number the minus sign is registered after the
// conversion; otherwise the first character waits for the leading-zero skip.
// A stall on the output holds the current beat and pauses the burst; the next
// number can be accepted while the final beat still waits to be taken.
// Reset empties the output register and returns the controller to idle.
module fixed_to_decimal_ascii_unit #(
  parameter int INT_BITS        = 31,
  parameter int FRAC_BITS       = 20,
  parameter int MAX_FRAC_DIGITS = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 negative,
  input  logic [INT_BITS-1:0]  int_part,
  input  logic [FRAC_BITS-1:0] frac_part,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           char_code,
  output logic                 last
);
  import fda_pkg::*;

  fda_cmd_t    cmd;
  fda_status_t status;

  // Sequencer.
  fda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Conversion registers and output beat register.
  fda_datapath #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .negative  (negative),
    .int_part  (int_part),
    .frac_part (frac_part),
    .cmd       (cmd),
    .status    (status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .char_code (char_code),
    .last      (last)
  );

endmodule
